### src/ipcs_pkg.sv
// Package: shared constants, command type and checksum helper for the checksum engine.
`timescale 1ns / 1ps
`default_nettype none
package ipcs_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = QPTR_W + 1;

   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;

   localparam logic [COUNT_WIDTH-1:0] POS_PROTO    = COUNT_WIDTH'(4);
   localparam logic [COUNT_WIDTH-1:0] POS_IP_SUM   = COUNT_WIDTH'(5);
   localparam logic [COUNT_WIDTH-1:0] POS_ADDR_LO  = COUNT_WIDTH'(6);
   localparam logic [COUNT_WIDTH-1:0] POS_ADDR_HI  = COUNT_WIDTH'(9);
   localparam logic [COUNT_WIDTH-1:0] TCP_SUM_WORD = COUNT_WIDTH'(8);
   localparam logic [COUNT_WIDTH-1:0] UDP_SUM_WORD = COUNT_WIDTH'(3);
   localparam logic [COUNT_WIDTH-1:0] POS_MAX      = {COUNT_WIDTH{1'b1}};

   localparam logic [3:0]  IHL_MIN   = 4'd5;
   localparam logic [15:0] TAIL_MASK = 16'hFF00;
   localparam logic [15:0] ALL_ONES  = 16'hFFFF;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_TCP  = 2'd1;
   localparam logic [1:0] KIND_UDP  = 2'd2;

   localparam logic [1:0] LEN_NONE = 2'd0;
   localparam logic [1:0] LEN_ONE  = 2'd1;
   localparam logic [1:0] LEN_TWO  = 2'd2;

   typedef struct packed {
      logic [15:0] word;
      logic        hdr_add;
      logic        pseudo_add;
      logic [1:0]  len_inc;
      logic        last;
      logic        trunc;
      logic [1:0]  kind;
      logic [7:0]  proto;
   } cmd_type;

   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

endpackage
`default_nettype wire

### src/ipcs_if.sv
// Interfaces: packet word request channel and checksum response channel.
`timescale 1ns / 1ps
`default_nettype none
interface ipcs_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] word;
   logic        last;
   logic        odd_tail;
   modport source(output valid, output word, output last, output odd_tail, input ready);
   modport sink(input valid, input word, input last, input odd_tail, output ready);
endinterface

interface ipcs_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] ip_checksum;
   logic [15:0] transport_checksum;
   logic [1:0]  transport_kind;
   logic        truncated;
   modport source(output valid, output ip_checksum, output transport_checksum,
                  output transport_kind, output truncated, input ready);
   modport sink(input valid, input ip_checksum, input transport_checksum,
                input transport_kind, input truncated, output ready);
endinterface
`default_nettype wire

### src/ipv4_tcp_udp_checksum_engine_core.sv
// Top level: IPv4 header and TCP/UDP checksum engine.
//
// Usage:
//   req_chan carries one 16-bit packet word per request, first byte in the
//   upper half; last marks the final word and odd_tail says that only its
//   upper byte is valid. One response per packet appears on rsp_chan with
//   the IPv4 header checksum, the TCP/UDP checksum including the
//   pseudo-header, the transport kind and a truncation flag.
//   Throughput: one word per cycle while req ready is high; the front end
//   classifies the word in the cycle it is accepted, the back end adds it
//   into end-around-carry sums. A 4-entry command queue sits between them.
//   The last word passes from the queue to the finish stage, which adds
//   protocol and length, and then on to the response register.
//   Reset clears position, header length, protocol, sums and all valid
//   flags; no clearing pass is needed.
//   When the receiver stalls, the response register and the finish stage
//   hold one packet each; words keep flowing until the next last word
//   finds the finish stage full and the queue fills, then req ready drops.
`timescale 1ns / 1ps
`default_nettype none
module ipv4_tcp_udp_checksum_engine_core (
   input  wire logic  clock,
   input  wire logic  reset,
   ipcs_req_if.sink   req_chan,
   ipcs_rsp_if.source rsp_chan
);
   import ipcs_pkg::*;

   cmd_type front_cmd;
   logic    front_valid;
   logic    front_ready;
   cmd_type back_cmd;
   logic    back_valid;
   logic    back_ready;

   ipcs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cmd       (front_cmd),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready)
   );

   ipcs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_data  (front_cmd),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .pop_data   (back_cmd),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready)
   );

   ipcs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (back_cmd),
      .cmd_valid (back_valid),
      .cmd_ready (back_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule
`default_nettype wire

### src/ipcs_front.sv
// Front end: tracks word position and header length, classifies each packet word.
`timescale 1ns / 1ps
`default_nettype none
module ipcs_front (
   input  wire logic             clock,
   input  wire logic             reset,
   ipcs_req_if.sink              req_chan,
   output ipcs_pkg::cmd_type     cmd,
   output logic                  cmd_valid,
   input  wire logic             cmd_ready
);
   import ipcs_pkg::*;

   logic [COUNT_WIDTH-1:0] pos_ff, pos_in;
   logic [4:0]             hwords_ff, hwords_in;
   logic [7:0]             proto_ff, proto_in;

   logic [15:0]            w;
   logic                   odd;
   logic [3:0]             ihl;
   logic [4:0]             hw;
   logic [COUNT_WIDTH-1:0] hw_ext;
   logic [COUNT_WIDTH-1:0] tpos;
   logic [COUNT_WIDTH:0]   pos_next;
   logic                   in_hdr;
   logic                   skip;
   logic                   trunc;
   logic                   accept;

   assign accept = req_chan.valid && cmd_ready;
   assign req_chan.ready = cmd_ready;
   assign cmd_valid = req_chan.valid;

   always_comb begin
      odd = req_chan.last && req_chan.odd_tail;
      w = odd ? (req_chan.word & TAIL_MASK) : req_chan.word;
      ihl = (w[11:8] < IHL_MIN) ? IHL_MIN : w[11:8];
      hw = (pos_ff == '0) ? {ihl, 1'b0} : hwords_ff;
      hw_ext = {{(COUNT_WIDTH-5){1'b0}}, hw};
      in_hdr = pos_ff < hw_ext;
      tpos = pos_ff - hw_ext;
      skip = ((proto_ff == PROTO_TCP) && (tpos == TCP_SUM_WORD)) ||
             ((proto_ff == PROTO_UDP) && (tpos == UDP_SUM_WORD));
      pos_next = {1'b0, pos_ff} + {{COUNT_WIDTH{1'b0}}, 1'b1};
      trunc = pos_next < {1'b0, hw_ext};

      cmd.word = w;
      cmd.hdr_add = in_hdr && (pos_ff != POS_IP_SUM);
      cmd.pseudo_add = in_hdr ? ((pos_ff >= POS_ADDR_LO) && (pos_ff <= POS_ADDR_HI)) : !skip;
      cmd.len_inc = in_hdr ? LEN_NONE : (odd ? LEN_ONE : LEN_TWO);
      cmd.last = req_chan.last;
      cmd.trunc = trunc;
      cmd.proto = proto_ff;
      if (trunc) begin
         cmd.kind = KIND_NONE;
      end else if (proto_ff == PROTO_TCP) begin
         cmd.kind = KIND_TCP;
      end else if (proto_ff == PROTO_UDP) begin
         cmd.kind = KIND_UDP;
      end else begin
         cmd.kind = KIND_NONE;
      end

      pos_in = pos_ff;
      hwords_in = hwords_ff;
      proto_in = proto_ff;
      if (accept) begin
         if (req_chan.last) begin
            pos_in = '0;
            hwords_in = '0;
            proto_in = '0;
         end else begin
            pos_in = (pos_ff < POS_MAX) ? pos_next[COUNT_WIDTH-1:0] : pos_ff;
            hwords_in = hw;
            if (in_hdr && (pos_ff == POS_PROTO)) begin
               proto_in = w[7:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         hwords_ff <= '0;
         proto_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         hwords_ff <= hwords_in;
         proto_ff <= proto_in;
      end
   end

endmodule
`default_nettype wire

### src/ipcs_queue.sv
// Command queue: small FIFO between front end and back end.
`timescale 1ns / 1ps
`default_nettype none
module ipcs_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ipcs_pkg::cmd_type push_data,
   input  wire logic              push_valid,
   output logic                   push_ready,
   output ipcs_pkg::cmd_type      pop_data,
   output logic                   pop_valid,
   input  wire logic              pop_ready
);
   import ipcs_pkg::*;

   cmd_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wptr_ff, wptr_in;
   logic [QPTR_W-1:0] rptr_ff, rptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push;
   logic              pop;

   assign push_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_data = mem_ff[rptr_ff];
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;

   always_comb begin
      wptr_in = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

### src/ipcs_back.sv
// Back end: running one's complement sums, pseudo-header finish and response register.
`timescale 1ns / 1ps
`default_nettype none
module ipcs_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ipcs_pkg::cmd_type cmd,
   input  wire logic              cmd_valid,
   output logic                   cmd_ready,
   ipcs_rsp_if.source             rsp_chan
);
   import ipcs_pkg::*;

   logic [15:0] hsum_ff, hsum_in;
   logic [15:0] psum_ff, psum_in;
   logic [15:0] bytes_ff, bytes_in;

   logic        fin_valid_ff, fin_valid_in;
   logic [15:0] fin_hsum_ff, fin_psum_ff, fin_bytes_ff;
   logic [7:0]  fin_proto_ff;
   logic [1:0]  fin_kind_ff;
   logic        fin_trunc_ff;

   logic        out_valid_ff, out_valid_in;
   logic [15:0] out_ip_ff, out_tr_ff;
   logic [1:0]  out_kind_ff;
   logic        out_trunc_ff;

   logic [15:0] hsum_add, psum_add, bytes_add;
   logic [15:0] fin_s1, fin_s2, fin_tr;
   logic        out_load;
   logic        fin_free;
   logic        pop;

   assign out_load = fin_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign fin_free = !fin_valid_ff || out_load;
   assign cmd_ready = !cmd.last || fin_free;
   assign pop = cmd_valid && cmd_ready;

   always_comb begin
      hsum_add = cmd.hdr_add ? oc_add(hsum_ff, cmd.word) : hsum_ff;
      psum_add = cmd.pseudo_add ? oc_add(psum_ff, cmd.word) : psum_ff;
      bytes_add = bytes_ff + {14'd0, cmd.len_inc};

      hsum_in = hsum_ff;
      psum_in = psum_ff;
      bytes_in = bytes_ff;
      if (pop) begin
         if (cmd.last) begin
            hsum_in = '0;
            psum_in = '0;
            bytes_in = '0;
         end else begin
            hsum_in = hsum_add;
            psum_in = psum_add;
            bytes_in = bytes_add;
         end
      end

      fin_valid_in = fin_valid_ff;
      if (out_load) begin
         fin_valid_in = 1'b0;
      end
      if (pop && cmd.last) begin
         fin_valid_in = 1'b1;
      end

      out_valid_in = out_valid_ff;
      if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if (out_load) begin
         out_valid_in = 1'b1;
      end

      fin_s1 = oc_add(fin_psum_ff, {8'd0, fin_proto_ff});
      fin_s2 = oc_add(fin_s1, fin_bytes_ff);
      fin_tr = ~fin_s2;
      if (fin_kind_ff == KIND_NONE) begin
         fin_tr = '0;
      end else if ((fin_kind_ff == KIND_UDP) && (fin_tr == '0)) begin
         fin_tr = ALL_ONES;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hsum_ff <= '0;
         psum_ff <= '0;
         bytes_ff <= '0;
         fin_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         hsum_ff <= hsum_in;
         psum_ff <= psum_in;
         bytes_ff <= bytes_in;
         fin_valid_ff <= fin_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && cmd.last) begin
         fin_hsum_ff <= hsum_add;
         fin_psum_ff <= psum_add;
         fin_bytes_ff <= bytes_add;
         fin_proto_ff <= cmd.proto;
         fin_kind_ff <= cmd.kind;
         fin_trunc_ff <= cmd.trunc;
      end
      if (out_load) begin
         out_ip_ff <= ~fin_hsum_ff;
         out_tr_ff <= fin_tr;
         out_kind_ff <= fin_kind_ff;
         out_trunc_ff <= fin_trunc_ff;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.ip_checksum = out_ip_ff;
   assign rsp_chan.transport_checksum = out_tr_ff;
   assign rsp_chan.transport_kind = out_kind_ff;
   assign rsp_chan.truncated = out_trunc_ff;

   a_last_has_room: assert property (@(posedge clock) disable iff (reset)
      (pop && cmd.last) |-> fin_free)
      else $error("last word popped while finish stage is occupied");

   a_trunc_no_kind: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_trunc_ff && (out_kind_ff != KIND_NONE)))
      else $error("truncated packet reported with a transport kind");

   a_none_zero_sum: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_kind_ff == KIND_NONE)) |-> (out_tr_ff == '0))
      else $error("transport checksum nonzero without transport kind");

   a_sums_clear: assert property (@(posedge clock) disable iff (reset)
      (pop && cmd.last) |=> ((hsum_ff == '0) && (psum_ff == '0) && (bytes_ff == '0)))
      else $error("running sums not cleared after packet end");

endmodule
`default_nettype wire
